[rtl/core/gdec_pkg.sv]
// Shared types and constants of the glyph outline decoder.
`timescale 1ns / 1ps

package gdec_pkg;

  localparam int MAX_RES = 4;
  localparam logic [31:0] CONTOUR_TYPE_OK = 32'd24;
  localparam logic [15:0] CURVE_LINE = 16'd1;
  localparam logic [15:0] CURVE_QUAD = 16'd2;

  typedef enum logic [1:0] {
    STATUS_POINT       = 2'd0,
    STATUS_DONE        = 2'd1,
    STATUS_BAD_CONTOUR = 2'd2,
    STATUS_BAD_CURVE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_CB      = 3'd0,
    PH_TYPE    = 3'd1,
    PH_START_X = 3'd2,
    PH_START_Y = 3'd3,
    PH_CURVE   = 3'd4,
    PH_PT_X    = 3'd5,
    PH_PT_Y    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_LINE      = 2'd1,
    KIND_QUAD      = 2'd2,
    KIND_QUAD_HELD = 2'd3
  } kind_t;

  typedef struct packed {
    logic        end_of_buffer;
    logic [31:0] buffer_word;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               begins_segment;
    logic               begins_contour;
    status_t            status;
    logic               last_of_run;
  } out_item_t;

  // one result without the end-of-run flag
  typedef struct packed {
    logic [63:0] point;   // y in the upper half
    logic        begins_segment;
    logic        begins_contour;
    status_t     status;
  } res_t;

  // all results caused by one buffer word
  typedef struct packed {
    logic [2:0]               count;
    res_t [MAX_RES-1:0]       slot;
  } bundle_t;

endpackage

[rtl/core/gdec_front.sv]
// Outline parser: takes one buffer word per cycle while the queue is not full and builds its result bundle.
`timescale 1ns / 1ps

module gdec_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  gdec_pkg::in_item_t in_data,
  output logic               in_ready,
  input  logic               queue_full,
  output logic               push,
  output gdec_pkg::bundle_t  push_data
);

  gdec_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] cbl_r, cbl_nxt;
  logic [15:0] left_r, left_nxt;
  gdec_pkg::kind_t kind_r, kind_nxt;
  logic [31:0] pend_r, pend_nxt;
  logic [63:0] held_r, held_nxt;
  logic [63:0] start_r, start_nxt;
  logic [63:0] last_r, last_nxt;
  logic        fso_r, fso_nxt;
  logic        disc_r, disc_nxt;

  logic        accept;
  logic [31:0] w;
  logic        eob;
  logic [15:0] curve_n;
  logic [15:0] curve_type;
  logic        dec_zero;
  logic [31:0] cbl_dec;
  logic [15:0] left_dec;
  logic        left_done;
  logic        curve_bad;
  logic        type_bad;
  logic [63:0] word_pt;
  logic [63:0] mid_pt;
  logic [2:0]  res_cnt;
  gdec_pkg::res_t [gdec_pkg::MAX_RES-1:0] res_set;

  function automatic logic [31:0] half_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    logic [32:0] t;
    begin
      s = {a[31], a} + {b[31], b};
      t = s + {32'd0, s[32]};   // round toward zero before the shift
      half_sum = t[32:1];
    end
  endfunction

  function automatic gdec_pkg::res_t mk_res(input logic [63:0] pt, input logic seg,
                                            input logic cont, input gdec_pkg::status_t st);
    gdec_pkg::res_t r;
    begin
      r.point          = pt;
      r.begins_segment = seg;
      r.begins_contour = cont;
      r.status         = st;
      mk_res           = r;
    end
  endfunction

  assign in_ready   = !queue_full;
  assign accept     = in_valid && !queue_full;
  assign w          = in_data.buffer_word;
  assign eob        = in_data.end_of_buffer;
  assign curve_n    = w[31:16];
  assign curve_type = w[15:0];
  assign dec_zero   = (cbl_r <= 32'd4);
  assign cbl_dec    = dec_zero ? 32'd0 : (cbl_r - 32'd4);
  assign left_dec   = left_r - 16'd1;
  assign left_done  = (left_dec == 16'd0);
  assign type_bad   = (w != gdec_pkg::CONTOUR_TYPE_OK);
  assign curve_bad  = ((curve_type != gdec_pkg::CURVE_LINE) && (curve_type != gdec_pkg::CURVE_QUAD))
                   || ((curve_type == gdec_pkg::CURVE_QUAD) && (curve_n == 16'd1));
  assign word_pt    = {w, pend_r};
  assign mid_pt     = {half_sum(held_r[63:32], w), half_sum(held_r[31:0], pend_r)};

  // next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (disc_r) begin
      if (eob) begin
        phase_nxt = gdec_pkg::PH_CB;
      end
    end else if (eob) begin
      phase_nxt = gdec_pkg::PH_CB;
    end else begin
      unique case (phase_r)
        gdec_pkg::PH_CB:      phase_nxt = gdec_pkg::PH_TYPE;
        gdec_pkg::PH_TYPE:    phase_nxt = type_bad ? phase_r : gdec_pkg::PH_START_X;
        gdec_pkg::PH_START_X: phase_nxt = gdec_pkg::PH_START_Y;
        gdec_pkg::PH_START_Y: phase_nxt = dec_zero ? gdec_pkg::PH_CB : gdec_pkg::PH_CURVE;
        gdec_pkg::PH_CURVE: begin
          if (curve_n == 16'd0) begin
            phase_nxt = dec_zero ? gdec_pkg::PH_CB : gdec_pkg::PH_CURVE;
          end else if (curve_bad) begin
            phase_nxt = phase_r;
          end else begin
            phase_nxt = gdec_pkg::PH_PT_X;
          end
        end
        gdec_pkg::PH_PT_X:    phase_nxt = gdec_pkg::PH_PT_Y;
        gdec_pkg::PH_PT_Y: begin
          if (left_done) begin
            phase_nxt = dec_zero ? gdec_pkg::PH_CB : gdec_pkg::PH_CURVE;
          end else begin
            phase_nxt = gdec_pkg::PH_PT_X;
          end
        end
        default:              phase_nxt = gdec_pkg::PH_TYPE;
      endcase
    end
  end

  // datapath updates and results
  always_comb begin
    gdec_pkg::res_t [gdec_pkg::MAX_RES-1:0] rv;
    logic [2:0]  cnt;
    logic        fso;
    logic        disc;
    logic [63:0] last;
    logic [63:0] start;

    rv        = '0;
    cnt       = 3'd0;
    fso       = fso_r;
    disc      = disc_r;
    last      = last_r;
    start     = start_r;
    cbl_nxt   = cbl_r;
    left_nxt  = left_r;
    kind_nxt  = kind_r;
    pend_nxt  = pend_r;
    held_nxt  = held_r;

    if (disc_r) begin
      if (eob) begin
        disc     = 1'b0;
        fso      = 1'b0;
        kind_nxt = gdec_pkg::KIND_NONE;
      end
    end else begin
      unique case (phase_r)
        gdec_pkg::PH_TYPE: begin
          cbl_nxt = cbl_dec;
          if (type_bad) begin
            rv[cnt[1:0]] = mk_res(64'd0, 1'b0, 1'b0, gdec_pkg::STATUS_BAD_CONTOUR);
            cnt  = cnt + 3'd1;
            disc = 1'b1;
          end
        end
        gdec_pkg::PH_START_X: begin
          cbl_nxt  = cbl_dec;
          pend_nxt = w;
        end
        gdec_pkg::PH_START_Y: begin
          cbl_nxt = cbl_dec;
          start   = word_pt;
          rv[cnt[1:0]] = mk_res(word_pt, 1'b1, 1'b1, gdec_pkg::STATUS_POINT);
          cnt  = cnt + 3'd1;
          last = word_pt;
          // a short contour closes at once; nothing to close since last equals start
          fso  = !dec_zero;
        end
        gdec_pkg::PH_CURVE: begin
          cbl_nxt = cbl_dec;
          if (curve_n == 16'd0) begin
            if (dec_zero) begin
              if (start_r != last) begin
                rv[cnt[1:0]] = mk_res(start_r, 1'b1, 1'b0, gdec_pkg::STATUS_POINT);
                cnt  = cnt + 3'd1;
                last = start_r;
              end
              fso = 1'b0;
            end
          end else if (curve_bad) begin
            rv[cnt[1:0]] = mk_res(64'd0, 1'b0, 1'b0, gdec_pkg::STATUS_BAD_CURVE);
            cnt  = cnt + 3'd1;
            disc = 1'b1;
          end else begin
            kind_nxt = (curve_type == gdec_pkg::CURVE_LINE) ? gdec_pkg::KIND_LINE
                                                             : gdec_pkg::KIND_QUAD;
            left_nxt = curve_n;
          end
        end
        gdec_pkg::PH_PT_X: begin
          cbl_nxt  = cbl_dec;
          pend_nxt = w;
        end
        gdec_pkg::PH_PT_Y: begin
          cbl_nxt  = cbl_dec;
          left_nxt = left_dec;
          if (kind_r == gdec_pkg::KIND_LINE) begin
            rv[cnt[1:0]] = mk_res(word_pt, !fso, 1'b0, gdec_pkg::STATUS_POINT);
            cnt  = cnt + 3'd1;
            fso  = 1'b0;
            last = word_pt;
          end else if (kind_r == gdec_pkg::KIND_QUAD_HELD) begin
            rv[cnt[1:0]] = mk_res(held_r, !fso, 1'b0, gdec_pkg::STATUS_POINT);
            cnt  = cnt + 3'd1;
            fso  = 1'b0;
            if (left_done) begin
              rv[cnt[1:0]] = mk_res(word_pt, 1'b0, 1'b0, gdec_pkg::STATUS_POINT);
              last = word_pt;
            end else begin
              rv[cnt[1:0]] = mk_res(mid_pt, 1'b0, 1'b0, gdec_pkg::STATUS_POINT);
              last = mid_pt;
            end
            cnt      = cnt + 3'd1;
            held_nxt = word_pt;
          end else begin
            held_nxt = word_pt;
            kind_nxt = gdec_pkg::KIND_QUAD_HELD;
          end
          if (left_done) begin
            kind_nxt = gdec_pkg::KIND_NONE;
            if (dec_zero) begin
              if (start_r != last) begin
                rv[cnt[1:0]] = mk_res(start_r, 1'b1, 1'b0, gdec_pkg::STATUS_POINT);
                cnt  = cnt + 3'd1;
                last = start_r;
              end
              fso = 1'b0;
            end
          end
        end
        default: begin
          // contour header: byte count word
          cbl_nxt = (w > 32'd4) ? (w - 32'd4) : 32'd0;
        end
      endcase

      if (eob) begin
        if (!disc) begin
          rv[cnt[1:0]] = mk_res(64'd0, 1'b0, 1'b0, gdec_pkg::STATUS_DONE);
          cnt = cnt + 3'd1;
        end
        disc     = 1'b0;
        fso      = 1'b0;
        kind_nxt = gdec_pkg::KIND_NONE;
      end
    end

    res_set   = rv;
    res_cnt   = cnt;
    fso_nxt   = fso;
    disc_nxt  = disc;
    last_nxt  = last;
    start_nxt = start;
  end

  assign push            = accept && (res_cnt != 3'd0);
  assign push_data.count = res_cnt;
  assign push_data.slot  = res_set;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= gdec_pkg::PH_CB;
      kind_r  <= gdec_pkg::KIND_NONE;
      fso_r   <= 1'b0;
      disc_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      fso_r   <= fso_nxt;
      disc_r  <= disc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cbl_r   <= cbl_nxt;
      left_r  <= left_nxt;
      pend_r  <= pend_nxt;
      held_r  <= held_nxt;
      start_r <= start_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

[rtl/core/gdec_queue.sv]
// Small bundle queue between the parser and the result sequencer.
`timescale 1ns / 1ps

module gdec_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gdec_pkg::bundle_t push_data,
  output logic              full,
  input  logic              pop,
  output gdec_pkg::bundle_t pop_data,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gdec_pkg::bundle_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/gdec_back.sv]
// Result sequencer: hands out the results of one bundle, one per transfer.
`timescale 1ns / 1ps

module gdec_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                queue_empty,
  input  gdec_pkg::bundle_t   queue_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output gdec_pkg::out_item_t out_data
);

  gdec_pkg::bundle_t cur_r, cur_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              busy_r, busy_nxt;
  logic              is_last;
  logic              fire;
  logic              load;
  gdec_pkg::res_t    sel;

  assign sel       = cur_r.slot[idx_r];
  assign is_last   = ({1'b0, idx_r} == (cur_r.count - 3'd1));
  assign out_valid = busy_r;
  assign fire      = busy_r && out_ready;
  assign load      = !queue_empty && (!busy_r || (fire && is_last));
  assign pop       = load;

  always_comb begin
    out_data.point_x        = sel.point[31:0];
    out_data.point_y        = sel.point[63:32];
    out_data.begins_segment = sel.begins_segment;
    out_data.begins_contour = sel.begins_contour;
    out_data.status         = sel.status;
    out_data.last_of_run    = is_last;
  end

  always_comb begin
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (load) begin
      cur_nxt  = queue_data;
      idx_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (fire) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

[rtl/core/glyph_outline_decoder_top.sv]
// Glyph outline decoder top level: parser, bundle queue and result sequencer.
// Throughput: one buffer word accepted per cycle while the queue is not full; results
//   leave one per cycle while out_ready is high, so a word that causes k results (0 to 4)
//   holds the result side for k transfers. The input stalls only while every queue entry holds a bundle.
// Path: the results of a word are written into the queue at the word's transfer edge
//   and loaded into the sequencer when it is idle or transfers its last result; the
//   first result is valid once loaded.
// Reset: rst_n synchronous, active low; parser waits for a contour header, queue
//   and sequencer empty. No clearing pass.
`timescale 1ns / 1ps

module glyph_outline_decoder_top #(
  parameter int QUEUE_DEPTH = 2   // bundles buffered between parser and sequencer
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gdec_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gdec_pkg::out_item_t out_data
);

  // front side: one word per transfer, results of the word packed in a bundle
  logic              push;
  gdec_pkg::bundle_t push_data;
  logic              q_full;

  // back side
  logic              pop;
  gdec_pkg::bundle_t pop_data;
  logic              q_empty;

  // Parser stalls only when the queue is full; words with no result push nothing.
  gdec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_ready   (in_ready),
    .queue_full (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  gdec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Sequencer reloads on the transfer of a bundle's last result, so no bubble while the queue holds a bundle.
  gdec_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (q_empty),
    .queue_data  (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
